// ===== rtl/asp_pkg.sv =====
package asp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IQ = 30;
  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 32;

  localparam logic [63:0] ONE_Q = 64'd1 << IQ;
  localparam logic [63:0] HALF_Q = 64'd1 << (IQ - 1);

  localparam logic [11:0] K_SQRT = 12'd2969;
  localparam logic [11:0] K_X1 = 12'd1260;
  localparam logic [11:0] K_X2 = 12'd3516;
  localparam logic [11:0] K_X3 = 12'd2843;
  localparam logic [11:0] K_X4 = 12'd1015;
  localparam logic [17:0] T_HALF = 18'd100000;

  // The thickness divisor 200000 is 3125 times 2^6. The reciprocal of 3125 is
  // scaled by 2^54 and rounded up, which is exact for dividends below 2^42.
  localparam int T_PRE_SH = 6;
  localparam int T_RECIP_SH = 54;
  localparam logic [42:0] T_RECIP = 43'd5764607523035;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [3:0] DIGIT_BASE = 4'd10;
  localparam logic [5:0] THICK_RESET = 6'd12;

  typedef enum logic [1:0] {
    REG_CAMBER   = 2'd0,
    REG_POSITION = 2'd1,
    REG_THICK    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] dsr;
    logic [31:0] rem;
    logic [31:0] nq;
  } dv_t;

  function automatic sq_t sq_init(logic [63:0] rad);
    sq_t o;
    o.rem = '0;
    o.root = '0;
    o.rad = rad;
    return o;
  endfunction

  function automatic sq_t sq_step(sq_t s);
    sq_t o;
    logic [34:0] r;
    logic [34:0] tr;
    r = {s.rem[32:0], s.rad[63:62]};
    tr = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[61:0], 2'b00};
    if (r >= tr) begin
      o.rem = r - tr;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem = r;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t dv_init(logic neg, logic [31:0] dsr, logic [63:0] u);
    dv_t o;
    o.neg = neg;
    o.dsr = dsr;
    o.rem = u[63:32];
    o.nq = u[31:0];
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t s);
    dv_t o;
    logic [32:0] r;
    r = {s.rem, s.nq[31]};
    o = s;
    if (r >= {1'b0, s.dsr}) begin
      o.rem = 32'(r - {1'b0, s.dsr});
      o.nq = {s.nq[30:0], 1'b1};
    end else begin
      o.rem = r[31:0];
      o.nq = {s.nq[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/airfoil_surface_point.sv =====
// Four-digit airfoil point evaluator, fully pipelined.
// Throughput: one chord position word per cycle while the result is not stalled.
// The depth of the pipeline is set by the chain of the 32-step slope divider,
// the 32-step square root of one plus the squared slope and the 32-step divider
// for the thickness term.
// The whole pipeline holds while a finished result word is stalled.
// Synchronous reset clears all valid bits and sets the registers to 0, 0 and 12.
module airfoil_surface_point import asp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        write_enable,
  input  logic [1:0]                  write_index,
  input  logic [5:0]                  write_data,
  input  logic                        point_valid,
  output logic                        point_stall,
  input  logic [FRAC_BITS:0]          chord_position,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [FRAC_BITS+1:0] upper_surface_y,
  output logic signed [FRAC_BITS+1:0] lower_surface_y,
  output logic signed [FRAC_BITS+1:0] camber_line_y,
  output logic signed [FRAC_BITS+1:0] half_thickness
);

  localparam int IW = FRAC_BITS + 1;
  localparam int OW = FRAC_BITS + 2;
  localparam int SH = IQ - FRAC_BITS;
  localparam int T_S = 1 + SQ_STEPS;
  localparam int T_YT = T_S + 7;
  localparam int T_CS = 5 + DV_STEPS + 1;
  localparam int T_R = T_CS + 2 + SQ_STEPS;
  localparam int T_TM = T_R + 1 + DV_STEPS + 1;
  localparam int LAT = T_TM + 3;
  localparam int X_LEN = T_S;
  localparam int X2_LEN = T_S - 1;
  localparam int X34_LEN = T_S - 2;
  localparam int YC_LEN = T_TM - T_CS + 1;
  localparam int YT_LEN = T_TM - T_YT + 1;
  localparam int YT_AT_R = T_R - T_YT;
  localparam logic [IW-1:0] X_ONE = IW'(1) << FRAC_BITS;
  localparam logic [34:0] RND_HALF = 35'(1) << (SH - 1);
  localparam logic [34:0] OUT_MAG = 35'(1) << FRAC_BITS;
  localparam logic signed [OW-1:0] OUT_LIM = OW'(1) << FRAC_BITS;

  logic [3:0] cam_m;
  logic [3:0] cam_p;
  logic [5:0] thick;
  logic [3:0] m_c;
  logic [3:0] p_c;

  logic [LAT-1:0] vld;
  logic           adv;

  logic [IW-1:0] x_c;
  logic [30:0]   x_dl [X_LEN];
  logic [30:0]   x2_dl [X2_LEN];
  logic [30:0]   x3_dl [X34_LEN];
  logic [30:0]   x4_dl [X34_LEN];
  logic [61:0]   p_x2;
  logic [61:0]   p_x3;
  logic [61:0]   p_x4;
  sq_t           sq_a [SQ_STEPS];

  logic [43:0]        pr [5];
  logic signed [44:0] ts_sum;
  logic signed [51:0] tn;
  logic [51:0]        tn_mag;
  logic [41:0]        tq_n;
  logic [42:0]        tq_p [4];
  logic [85:0]        tq_sum;
  logic [2:0]         tq_neg;
  logic signed [32:0] yt_dl [YT_LEN];

  logic [34:0]        x10;
  logic               fwd;
  logic               pz;
  logic signed [36:0] px_s;
  logic signed [36:0] x25_s;
  logic signed [36:0] a_fwd;
  logic signed [36:0] off_aft;
  logic signed [36:0] a_sel;
  logic signed [36:0] b_sel;
  logic [3:0]         q10;
  logic [8:0]         d_fwd;
  logic [8:0]         d_aft;
  logic [8:0]         d_sel;
  logic signed [36:0] ca_a;
  logic signed [36:0] ca_b;
  logic [8:0]         ca_d;
  logic signed [40:0] cm_y;
  logic signed [40:0] cm_s;
  logic [8:0]         cm_d;
  logic [40:0]        cmy_mag;
  logic [40:0]        cms_mag;
  dv_t                cy0;
  dv_t                sd0;
  dv_t                cy_a [DV_STEPS];
  dv_t                sd_a [DV_STEPS];
  logic signed [32:0] yc_dl [YC_LEN];
  logic signed [32:0] sl_r;
  logic [31:0]        us;
  logic [63:0]        sq_r;
  sq_t                rt0;
  sq_t                rt_a [SQ_STEPS];

  logic [31:0]        ytm;
  dv_t                tm0;
  dv_t                tm_a [DV_STEPS];
  logic signed [32:0] term_r;

  logic signed [33:0] sv [4];
  logic [34:0]        sv_mag [4];
  logic [34:0]        rnd [4];
  logic               rn_neg [4];
  logic [34:0]        rn_mag [4];
  logic [34:0]        sat [4];
  logic signed [OW-1:0] o_y [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_m <= '0;
      cam_p <= '0;
      thick <= THICK_RESET;
    end else if (write_enable) begin
      case (write_index)
        REG_CAMBER:   cam_m <= write_data[3:0];
        REG_POSITION: cam_p <= write_data[3:0];
        REG_THICK:    thick <= write_data;
        default: ;
      endcase
    end
  end

  assign m_c = (cam_m > DIGIT_MAX) ? DIGIT_MAX : cam_m;
  assign p_c = (cam_p > DIGIT_MAX) ? DIGIT_MAX : cam_p;

  assign adv = !(vld[LAT-1] && result_stall);
  assign point_stall = !adv;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], point_valid};
    end
  end

  assign x_c = (chord_position > X_ONE) ? X_ONE : chord_position;
  assign p_x2 = x_dl[0] * x_dl[0] + 62'(HALF_Q);
  assign p_x3 = x2_dl[0] * x_dl[1] + 62'(HALF_Q);
  assign p_x4 = x2_dl[0] * x2_dl[0] + 62'(HALF_Q);

  assign x10 = {1'b0, x_dl[1], 3'b000} + {3'b000, x_dl[1], 1'b0};
  assign fwd = x10 <= (35'(p_c) << IQ);
  assign pz = p_c == '0;
  assign px_s = signed'(37'(p_c) * 37'(x_dl[1]));
  assign x25_s = signed'(37'(x2_dl[0]) * 37'(5));
  assign a_fwd = px_s - x25_s;
  assign off_aft = signed'(37'(5)) - signed'(37'(p_c));
  assign a_sel = pz ? '0 : (fwd ? a_fwd : a_fwd + (off_aft <<< IQ));
  assign b_sel = pz ? '0 : signed'(37'(p_c) << IQ) - signed'(37'(x10));
  assign q10 = DIGIT_BASE - p_c;
  assign d_fwd = 9'(p_c) * 9'(p_c) * 9'(5);
  assign d_aft = 9'(q10) * 9'(q10) * 9'(5);
  assign d_sel = pz ? 9'(5) : (fwd ? d_fwd : d_aft);

  assign tn_mag = tn[51] ? 52'(-tn) : 52'(tn);
  assign cmy_mag = cm_y[40] ? 41'(-cm_y) : 41'(cm_y);
  assign cms_mag = cm_s[40] ? 41'(-cm_s) : 41'(cm_s);
  assign us = sl_r[32] ? 32'(-sl_r) : 32'(sl_r);
  assign ytm = yt_dl[YT_AT_R][32] ? 32'(-yt_dl[YT_AT_R]) : 32'(yt_dl[YT_AT_R]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sv_mag[i] = sv[i][33] ? 35'(-35'(sv[i])) : 35'(sv[i]);
      rnd[i] = (sv_mag[i] + RND_HALF) >> SH;
      sat[i] = (rn_mag[i] > OUT_MAG) ? OUT_MAG : rn_mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_dl[0] <= 31'(x_c) << SH;
      for (int i = 1; i < X_LEN; i++) x_dl[i] <= x_dl[i-1];
      x2_dl[0] <= 31'(p_x2 >> IQ);
      for (int i = 1; i < X2_LEN; i++) x2_dl[i] <= x2_dl[i-1];
      x3_dl[0] <= 31'(p_x3 >> IQ);
      x4_dl[0] <= 31'(p_x4 >> IQ);
      for (int i = 1; i < X34_LEN; i++) begin
        x3_dl[i] <= x3_dl[i-1];
        x4_dl[i] <= x4_dl[i-1];
      end
      sq_a[0] <= sq_step(sq_init(64'(x_dl[0]) << IQ));
      for (int i = 1; i < SQ_STEPS; i++) sq_a[i] <= sq_step(sq_a[i-1]);

      pr[0] <= 44'(sq_a[SQ_STEPS-1].root) * 44'(K_SQRT);
      pr[1] <= 44'(x_dl[X_LEN-1]) * 44'(K_X1);
      pr[2] <= 44'(x2_dl[X2_LEN-1]) * 44'(K_X2);
      pr[3] <= 44'(x3_dl[X34_LEN-1]) * 44'(K_X3);
      pr[4] <= 44'(x4_dl[X34_LEN-1]) * 44'(K_X4);
      ts_sum <= signed'(45'(pr[0])) - signed'(45'(pr[1])) - signed'(45'(pr[2]))
                + signed'(45'(pr[3])) - signed'(45'(pr[4]));
      tn <= 52'(ts_sum) * signed'(52'(thick));
      tq_n <= 42'((64'(tn_mag) + 64'(T_HALF)) >> T_PRE_SH);
      tq_neg[0] <= tn[51];
      tq_p[0] <= 43'(tq_n[20:0]) * 43'(T_RECIP[21:0]);
      tq_p[1] <= 43'(tq_n[20:0]) * 43'(T_RECIP[42:22]);
      tq_p[2] <= 43'(tq_n[41:21]) * 43'(T_RECIP[21:0]);
      tq_p[3] <= 43'(tq_n[41:21]) * 43'(T_RECIP[42:22]);
      tq_neg[1] <= tq_neg[0];
      tq_sum <= 86'(tq_p[0]) + (86'(tq_p[1]) << 22) + (86'(tq_p[2]) << 21)
                + (86'(tq_p[3]) << 43);
      tq_neg[2] <= tq_neg[1];
      yt_dl[0] <= tq_neg[2] ? -signed'(33'(tq_sum[T_RECIP_SH +: 31]))
                            : signed'(33'(tq_sum[T_RECIP_SH +: 31]));
      for (int i = 1; i < YT_LEN; i++) yt_dl[i] <= yt_dl[i-1];

      ca_a <= a_sel;
      ca_b <= b_sel;
      ca_d <= d_sel;
      cm_y <= 41'(ca_a) * signed'(41'(m_c));
      cm_s <= 41'(ca_b) * signed'(41'(m_c));
      cm_d <= ca_d;
      cy0 <= dv_init(cm_y[40], 32'(cm_d), 64'(cmy_mag) + 64'(cm_d >> 1));
      sd0 <= dv_init(cm_s[40], 32'(cm_d), 64'(cms_mag) + 64'(cm_d >> 1));
      cy_a[0] <= dv_step(cy0);
      sd_a[0] <= dv_step(sd0);
      for (int i = 1; i < DV_STEPS; i++) begin
        cy_a[i] <= dv_step(cy_a[i-1]);
        sd_a[i] <= dv_step(sd_a[i-1]);
      end
      yc_dl[0] <= cy_a[DV_STEPS-1].neg ? -signed'(33'(cy_a[DV_STEPS-1].nq))
                                       : signed'(33'(cy_a[DV_STEPS-1].nq));
      for (int i = 1; i < YC_LEN; i++) yc_dl[i] <= yc_dl[i-1];
      sl_r <= sd_a[DV_STEPS-1].neg ? -signed'(33'(sd_a[DV_STEPS-1].nq))
                                   : signed'(33'(sd_a[DV_STEPS-1].nq));
      sq_r <= 64'(us) * 64'(us);
      rt0 <= sq_init((ONE_Q + ((sq_r + HALF_Q) >> IQ)) << IQ);
      rt_a[0] <= sq_step(rt0);
      for (int i = 1; i < SQ_STEPS; i++) rt_a[i] <= sq_step(rt_a[i-1]);

      tm0 <= dv_init(yt_dl[YT_AT_R][32], rt_a[SQ_STEPS-1].root,
                     (64'(ytm) << IQ) + 64'(rt_a[SQ_STEPS-1].root >> 1));
      tm_a[0] <= dv_step(tm0);
      for (int i = 1; i < DV_STEPS; i++) tm_a[i] <= dv_step(tm_a[i-1]);
      term_r <= tm_a[DV_STEPS-1].neg ? -signed'(33'(tm_a[DV_STEPS-1].nq))
                                     : signed'(33'(tm_a[DV_STEPS-1].nq));

      sv[0] <= 34'(yc_dl[YC_LEN-1]) + 34'(term_r);
      sv[1] <= 34'(yc_dl[YC_LEN-1]) - 34'(term_r);
      sv[2] <= 34'(yc_dl[YC_LEN-1]);
      sv[3] <= 34'(yt_dl[YT_LEN-1]);
      for (int i = 0; i < 4; i++) begin
        rn_neg[i] <= sv[i][33];
        rn_mag[i] <= rnd[i];
        o_y[i] <= rn_neg[i] ? OW'(35'(0) - sat[i]) : OW'(sat[i]);
      end
    end
  end

  assign upper_surface_y = o_y[0];
  assign lower_surface_y = o_y[1];
  assign camber_line_y = o_y[2];
  assign half_thickness = o_y[3];

  a_upper_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (upper_surface_y <= OUT_LIM && upper_surface_y >= -OUT_LIM))
    else $error("upper surface out of range");

  a_lower_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (lower_surface_y <= OUT_LIM && lower_surface_y >= -OUT_LIM))
    else $error("lower surface out of range");

  a_flat_camber: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (m_c == '0 || p_c == '0)) |->
      (camber_line_y == '0 && upper_surface_y == -lower_surface_y &&
       upper_surface_y == half_thickness))
    else $error("symmetric profile gives uneven surfaces");

endmodule
